@@ hw/rtl/ifd_pkg.sv @@
`default_nettype none

package ifd_pkg;

    // Frame codes
    localparam logic [7:0] HDR_VALID  = 8'h55;
    localparam logic [7:0] TYPE_ACCEL = 8'h51;
    localparam logic [7:0] TYPE_RATE  = 8'h52;
    localparam logic [7:0] TYPE_ANGLE = 8'h53;

    // 321126/65536 ~ 16*9.8*1024/32768, 63053/65536 ~ 9.8*pi*1024/32768
    localparam logic signed [19:0] ACC_GAIN  = 20'sd321126;
    localparam logic signed [16:0] TILT_GAIN = 17'sd63053;

    localparam int RAW_W   = 16;
    localparam int ACC_W   = 19;
    localparam int APROD_W = 36;
    localparam int TPROD_W = 33;
    localparam int SUM_W   = 37;
    localparam int SHIFT   = 16;

    typedef logic signed [RAW_W-1:0] ifd_word_t;
    typedef logic signed [ACC_W-1:0] ifd_acc_t;

    // Stored values after the frame has been applied
    typedef struct packed {
        ifd_word_t [2:0] accel;
        ifd_word_t [2:0] rate;
        ifd_word_t [2:0] angle;
    } ifd_snap_t;

    typedef struct packed {
        ifd_acc_t        accel_z_out;
        ifd_acc_t        accel_y_comp;
        ifd_acc_t        accel_x_comp;
        ifd_word_t [2:0] rate;
        ifd_word_t [2:0] angle;
    } ifd_result_t;

endpackage

`default_nettype wire

@@ hw/rtl/ifd_store.sv @@
`default_nettype none

module ifd_store (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire logic [7:0]        header_byte,
    input  wire logic [7:0]        frame_type,
    input  wire ifd_pkg::ifd_word_t raw_first,
    input  wire ifd_pkg::ifd_word_t raw_second,
    input  wire ifd_pkg::ifd_word_t raw_third,
    output logic                   snap_valid,
    input  wire logic              snap_ready,
    output ifd_pkg::ifd_snap_t     snap
);
    import ifd_pkg::*;

    ifd_snap_t store_reg;
    ifd_snap_t store_next;
    logic      valid_reg;
    logic      valid_next;
    logic      accept;

    // The stores double as the stage register: they change only when the
    // previous snapshot has left or is leaving.
    assign in_ready = !valid_reg || snap_ready;
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        store_next = store_reg;
        if (accept && header_byte == HDR_VALID)
        begin
            case (frame_type)
                TYPE_ACCEL: store_next.accel = {raw_third, raw_second, raw_first};
                TYPE_RATE:  store_next.rate  = {raw_third, raw_second, raw_first};
                TYPE_ANGLE: store_next.angle = {raw_third, raw_second, raw_first};
                default:    store_next = store_reg;
            endcase
        end
        if (accept)
            valid_next = 1'b1;
        else if (snap_ready)
            valid_next = 1'b0;
        else
            valid_next = valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            store_reg <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            store_reg <= store_next;
            valid_reg <= valid_next;
        end
    end

    assign snap_valid = valid_reg;
    assign snap       = store_reg;

endmodule

`default_nettype wire

@@ hw/rtl/ifd_comp.sv @@
`default_nettype none

module ifd_comp (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              snap_valid,
    output logic                   snap_ready,
    input  wire ifd_pkg::ifd_snap_t snap,
    output logic                   res_valid,
    input  wire logic              res_ready,
    output ifd_pkg::ifd_result_t   res
);
    import ifd_pkg::*;

    logic signed [APROD_W-1:0] prod_ax, prod_ay, prod_az;
    logic signed [TPROD_W-1:0] prod_tx, prod_ty;
    logic signed [SUM_W-1:0]   sum_x, sum_y, sum_z;

    // Result stage
    ifd_result_t               res_reg;
    ifd_result_t               res_next;
    logic                      rvalid_reg;
    logic                      rvalid_next;
    logic                      load;

    assign snap_ready = !rvalid_reg || res_ready;
    assign load       = snap_valid && snap_ready;

    // Constant multiplies, add/subtract, then drop the low
    // fraction bits (arithmetic shift right)
    always_comb
    begin
        prod_ax = APROD_W'(snap.accel[0]) * APROD_W'(ACC_GAIN);
        prod_ay = APROD_W'(snap.accel[1]) * APROD_W'(ACC_GAIN);
        prod_az = APROD_W'(snap.accel[2]) * APROD_W'(ACC_GAIN);
        prod_tx = TPROD_W'(snap.angle[1]) * TPROD_W'(TILT_GAIN);
        prod_ty = TPROD_W'(snap.angle[0]) * TPROD_W'(TILT_GAIN);
        sum_x = SUM_W'(prod_ax) + SUM_W'(prod_tx);
        sum_y = SUM_W'(prod_ay) - SUM_W'(prod_ty);
        sum_z = SUM_W'(prod_az);
        res_next.accel_x_comp = sum_x[SHIFT+ACC_W-1:SHIFT];
        res_next.accel_y_comp = sum_y[SHIFT+ACC_W-1:SHIFT];
        res_next.accel_z_out  = sum_z[SHIFT+ACC_W-1:SHIFT];
        res_next.rate         = snap.rate;
        res_next.angle        = snap.angle;

        if (load)
            rvalid_next = 1'b1;
        else if (res_ready)
            rvalid_next = 1'b0;
        else
            rvalid_next = rvalid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (load)
            res_reg <= res_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rvalid_reg <= 1'b0;
        else
            rvalid_reg <= rvalid_next;
    end

    assign res_valid = rvalid_reg;
    assign res       = res_reg;

endmodule

`default_nettype wire

@@ hw/rtl/imu_frame_decode_tilt_comp_top.sv @@
`default_nettype none

// Channel   | Direction | Contents
// ----------+-----------+-----------------------------------------------------
// s_axis    | in        | one decoded frame: tuser = header, type; tdata = x,y,z
// m_axis    | out       | nine values: acceleration (x,y compensated), rates, angles
//
// One transfer in per cycle, one transfer out per cycle sustained while
// m_axis_tready stays high. Each frame updates the stores, then is multiplied,
// added or subtracted and shifted into the result register.
// Reset clears the acceleration, rate and angle stores to zero.
// A stall on m_axis holds the result register and then the store snapshot;
// s_axis keeps accepting until both are full.
module imu_frame_decode_tilt_comp_top (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    // [15:0] raw_first, [31:16] raw_second, [47:32] raw_third
    input  wire logic [47:0]  s_axis_tdata,
    // [7:0] header_byte, [15:8] frame_type
    input  wire logic [15:0]  s_axis_tuser,
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    // [18:0] accel_x_comp, [37:19] accel_y_comp, [56:38] accel_z_out,
    // [72:57] rate_x_out, [88:73] rate_y_out, [104:89] rate_z_out,
    // [120:105] angle_x_out, [136:121] angle_y_out, [152:137] angle_z_out,
    // [159:153] zero
    output logic [159:0]      m_axis_tdata
);
    import ifd_pkg::*;

    ifd_snap_t   snap;
    logic        snap_valid;
    logic        snap_ready;
    ifd_result_t res;

    // Apply the frame to the stores and hold the snapshot for the datapath
    ifd_store u_store (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (s_axis_tvalid),
        .in_ready    (s_axis_tready),
        .header_byte (s_axis_tuser[7:0]),
        .frame_type  (s_axis_tuser[15:8]),
        .raw_first   (s_axis_tdata[15:0]),
        .raw_second  (s_axis_tdata[31:16]),
        .raw_third   (s_axis_tdata[47:32]),
        .snap_valid  (snap_valid),
        .snap_ready  (snap_ready),
        .snap        (snap)
    );

    // Scale acceleration; add (x) or subtract (y) the tilt term from the angles
    ifd_comp u_comp (
        .clk        (clk),
        .rst_n      (rst_n),
        .snap_valid (snap_valid),
        .snap_ready (snap_ready),
        .snap       (snap),
        .res_valid  (m_axis_tvalid),
        .res_ready  (m_axis_tready),
        .res        (res)
    );

    // Pack lowest field first, pad to whole bytes
    assign m_axis_tdata = {7'd0,
                           res.angle[2], res.angle[1], res.angle[0],
                           res.rate[2],  res.rate[1],  res.rate[0],
                           res.accel_z_out, res.accel_y_comp, res.accel_x_comp};

endmodule

`default_nettype wire
